// ===== hdl/pmt_pkg.sv =====
// ----------------------------------------------------------------------------
// pmt_pkg
// Shared types, constants and helpers for the page mapping table.
// ----------------------------------------------------------------------------
package pmt_pkg;

  localparam int DEF_MAX_ENTRIES = 256;
  localparam int DEF_PAGE_BITS   = 12;

  localparam int ADDR_W  = 32;
  localparam int COUNT_W = 9;   // width of the reported count

  // Payload widths on the stream ports
  localparam int S_DATA_W = 64; // virt_addr, phys_addr
  localparam int M_DATA_W = 48; // status, translated_addr, mapped_count, pad

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NULL_PHYS = 3'd1,
    ST_UNALIGNED = 3'd2,
    ST_FULL      = 3'd3,
    ST_MISS      = 3'd4
  } status_t;

  localparam logic FUNC_MAP       = 1'b0;
  localparam logic FUNC_TRANSLATE = 1'b1;

  typedef struct packed {
    status_t             status;
    logic [ADDR_W-1:0]   addr;
    logic [COUNT_W-1:0]  count;
  } res_t;

  // Index width for a table of n entries, never zero
  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// ===== hdl/pmt_ram.sv =====
// ----------------------------------------------------------------------------
// pmt_ram
// Simple dual-port synchronous RAM, one write and one registered read.
// ----------------------------------------------------------------------------
module pmt_ram #(
  parameter int DEPTH = pmt_pkg::DEF_MAX_ENTRIES,
  parameter int WIDTH = pmt_pkg::ADDR_W,
  localparam int AW   = pmt_pkg::idx_w(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/pmt_ctrl.sv =====
// ----------------------------------------------------------------------------
// pmt_ctrl
// Request sequencer: checks, linear table scan, update and result.
// ----------------------------------------------------------------------------
module pmt_ctrl #(
  parameter int MAX_ENTRIES = pmt_pkg::DEF_MAX_ENTRIES,
  parameter int PAGE_BITS   = pmt_pkg::DEF_PAGE_BITS,
  localparam int IDX_W      = pmt_pkg::idx_w(MAX_ENTRIES),
  localparam int VPN_W      = pmt_pkg::ADDR_W - PAGE_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_func,
  input  logic [pmt_pkg::ADDR_W-1:0] in_va,
  input  logic [pmt_pkg::ADDR_W-1:0] in_pa,
  output logic                      res_valid,
  input  logic                      res_ready,
  output pmt_pkg::res_t             res,
  output logic                      vp_we,
  output logic                      pa_we,
  output logic [IDX_W-1:0]          ram_waddr,
  output logic [VPN_W-1:0]          vp_wdata,
  output logic [pmt_pkg::ADDR_W-1:0] pa_wdata,
  output logic [IDX_W-1:0]          ram_raddr,
  input  logic [VPN_W-1:0]          vp_rdata,
  input  logic [pmt_pkg::ADDR_W-1:0] pa_rdata
);

  import pmt_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_SEND
  } state_t;

  state_t             state;
  logic               func_q;
  logic [ADDR_W-1:0]  va_q;
  logic [ADDR_W-1:0]  pa_q;
  logic [IDX_W-1:0]   chk_idx;
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic [ADDR_W-1:0]  hit_phys;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;

  logic [VPN_W-1:0]   page_q;
  logic [ADDR_W-1:0]  offset_q;
  logic               in_beat;
  logic               is_full;

  assign page_q   = va_q[ADDR_W-1:PAGE_BITS];
  assign offset_q = ADDR_W'(va_q[PAGE_BITS-1:0]);
  assign in_beat  = in_valid && in_ready;
  assign is_full  = (count == CNT_MAX);
  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_SEND);

  // Table port drive: reads stream ahead of the compare by one entry,
  // writes happen only in the finish step.
  always_comb begin
    ram_raddr  = '0;
    ram_waddr  = hit ? hit_idx : count[IDX_W-1:0];
    vp_wdata   = page_q;
    pa_wdata   = pa_q;
    vp_we      = 1'b0;
    pa_we      = 1'b0;
    count_next = count;
    if (state == S_SCAN) begin
      ram_raddr = chk_idx + 1'b1;
    end
    if (state == S_FINISH && func_q == FUNC_MAP) begin
      if (hit) begin
        pa_we = 1'b1;
      end else if (!is_full) begin
        vp_we      = 1'b1;
        pa_we      = 1'b1;
        count_next = count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      count <= count_next;
      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            func_q    <= in_func;
            va_q      <= in_va;
            pa_q      <= in_pa;
            chk_idx   <= '0;
            hit       <= 1'b0;
            res.addr  <= '0;
            res.count <= COUNT_W'(count);
            if (in_func == FUNC_MAP && in_pa == '0) begin
              res.status <= ST_NULL_PHYS;
              state      <= S_SEND;
            end else if (in_func == FUNC_MAP && in_va[PAGE_BITS-1:0] != '0) begin
              res.status <= ST_UNALIGNED;
              state      <= S_SEND;
            end else if (count == '0) begin
              state <= S_FINISH;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (vp_rdata == page_q) begin
            hit      <= 1'b1;
            hit_idx  <= chk_idx;
            hit_phys <= pa_rdata;
            state    <= S_FINISH;
          end else if (CNT_W'(chk_idx) + 1'b1 == count) begin
            state <= S_FINISH;
          end else begin
            chk_idx <= chk_idx + 1'b1;
          end
        end
        S_FINISH: begin
          res.count <= COUNT_W'(count_next);
          res.addr  <= '0;
          if (func_q == FUNC_TRANSLATE) begin
            if (hit) begin
              res.status <= ST_OK;
              res.addr   <= hit_phys + offset_q;
            end else begin
              res.status <= ST_MISS;
            end
          end else if (!hit && is_full) begin
            res.status <= ST_FULL;
          end else begin
            res.status <= ST_OK;
          end
          state <= S_SEND;
        end
        S_SEND: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/page_mapping_table.sv =====
// ----------------------------------------------------------------------------
// page_mapping_table
// Linear page table: map/remap virtual pages, translate virtual addresses.
// ----------------------------------------------------------------------------
// Usage
//   s_axis: one request per beat. tuser[0] = func (0 map, 1 translate),
//   tdata = {phys_addr, virt_addr}. m_axis: exactly one result beat per
//   request, tdata = {pad, mapped_count, translated_addr, status}.
// Timing
//   Requests are handled one at a time. Rejected maps (null physical or
//   unaligned) go straight from accept to the result state. Otherwise the
//   table is scanned in insertion order, one entry per cycle out of the
//   page RAM, then the finish step updates the table and forms the result.
//   The single read port of the table RAM sets the scan rate.
// Reset
//   rst (synchronous) empties the table; RAM contents are not cleared,
//   only entries below the fill count are ever compared.
// Backpressure
//   Results sit in an output register. While m_axis is stalled the next
//   request is still accepted and processed; it waits for the register.
// ----------------------------------------------------------------------------
module page_mapping_table #(
  parameter int MAX_ENTRIES = pmt_pkg::DEF_MAX_ENTRIES,
  parameter int PAGE_BITS   = pmt_pkg::DEF_PAGE_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // [31:0] virt_addr, [63:32] phys_addr
  input  logic [pmt_pkg::S_DATA_W-1:0] s_axis_tdata,
  // [0] func
  input  logic [0:0]                  s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [2:0] status, [34:3] translated_addr, [43:35] mapped_count, [47:44] zero
  output logic [pmt_pkg::M_DATA_W-1:0] m_axis_tdata
);

  import pmt_pkg::*;

  localparam int IDX_W = idx_w(MAX_ENTRIES);
  localparam int VPN_W = ADDR_W - PAGE_BITS;
  localparam int PAD_W = M_DATA_W - $bits(res_t);

  logic               res_valid;
  logic               res_ready;
  res_t               res;
  logic               vp_we;
  logic               pa_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [IDX_W-1:0]   ram_raddr;
  logic [VPN_W-1:0]   vp_wdata;
  logic [VPN_W-1:0]   vp_rdata;
  logic [ADDR_W-1:0]  pa_wdata;
  logic [ADDR_W-1:0]  pa_rdata;

  // Sequencer: checks, scan, update
  pmt_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .PAGE_BITS   (PAGE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_func   (s_axis_tuser[0]),
    .in_va     (s_axis_tdata[ADDR_W-1:0]),
    .in_pa     (s_axis_tdata[2*ADDR_W-1:ADDR_W]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .vp_we     (vp_we),
    .pa_we     (pa_we),
    .ram_waddr (ram_waddr),
    .vp_wdata  (vp_wdata),
    .pa_wdata  (pa_wdata),
    .ram_raddr (ram_raddr),
    .vp_rdata  (vp_rdata),
    .pa_rdata  (pa_rdata)
  );

  // Virtual page numbers, in insertion order
  pmt_ram #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (VPN_W)
  ) u_vp_ram (
    .clk   (clk),
    .we    (vp_we),
    .waddr (ram_waddr),
    .wdata (vp_wdata),
    .raddr (ram_raddr),
    .rdata (vp_rdata)
  );

  // Physical addresses, same index as the page RAM
  pmt_ram #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (ADDR_W)
  ) u_pa_ram (
    .clk   (clk),
    .we    (pa_we),
    .waddr (ram_waddr),
    .wdata (pa_wdata),
    .raddr (ram_raddr),
    .rdata (pa_rdata)
  );

  // Output register: loads when empty or being drained this cycle
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_axis_tdata <= {PAD_W'(0), res.count, res.addr, res.status};
    end
  end

endmodule

// ===== hdl/pmt_check.sv =====
// ----------------------------------------------------------------------------
// pmt_check
// Port-level checks for page_mapping_table, bound to the top level.
// ----------------------------------------------------------------------------
module pmt_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [pmt_pkg::S_DATA_W-1:0] s_axis_tdata,
  input logic [0:0]                  s_axis_tuser,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [pmt_pkg::M_DATA_W-1:0] m_axis_tdata
);

  import pmt_pkg::*;

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // One request in flight: no accept on the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted back to back");

  // Any failed request reports a zero address
  a_err_zero_addr: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2:0] != ST_OK |-> m_axis_tdata[34:3] == '0)
    else $error("nonzero address on a failed request");

  // Output empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind page_mapping_table pmt_check u_check (.*);
